FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the matrix builder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/trs_pkg.sv
// ----------------------------------------------------------------------------
// trs_pkg
// Shared constants, types and arithmetic helpers for the TRS matrix builder.
// ----------------------------------------------------------------------------
package trs_pkg;

    typedef logic signed [31:0] t_q32;
    typedef logic signed [34:0] t_ang;
    typedef logic signed [33:0] t_cvec;

    localparam int unsigned CordicStagesDef = 16;
    localparam int unsigned AtanLen         = 24;
    localparam int unsigned FracBits        = 16;

    localparam t_ang  PiQ30     = 35'sd3373259426;
    localparam t_ang  HalfPiQ30 = 35'sd1686629713;
    localparam t_ang  TwoPiQ30  = 35'sd6746518852;
    localparam t_cvec GainQ30   = 34'sd652032874;
    localparam t_q32  UnityQ    = 32'sd1 <<< FracBits;

    localparam logic [1:0] LastCol = 2'd3;

    localparam logic [31:0] AtanQ30 [AtanLen] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    // Q30 product, round half up, back to Q30
    function automatic t_q32 mul30(input t_q32 a, input t_q32 b);
        logic signed [63:0] p;
        logic signed [63:0] q;
        begin
            p = a * b;
            q = (p + 64'sd536870912) >>> 30;
            return q[31:0];
        end
    endfunction

    // Q30 by Q16.16 product already formed: round, shift, saturate
    function automatic t_q32 rnd_sat(input logic signed [63:0] p);
        logic signed [63:0] q;
        begin
            q = (p + 64'sd536870912) >>> 30;
            if (q > 64'sd2147483647) begin
                return 32'sh7FFFFFFF;
            end else if (q < -64'sd2147483648) begin
                return 32'sh80000000;
            end
            return q[31:0];
        end
    endfunction

endpackage

FILE: hw/rtl/trs_matrix_builder.sv
// ----------------------------------------------------------------------------
// trs_matrix_builder
// Builds the 4x4 local-to-world matrix T*Rz*Ry*Rx*S from position, scale and
// Euler angles, and sends it out one column per transfer.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall with position, scale (Q16.16) and angles
// (Q4.12 radians). Output channel: o_valid / i_stall with column_index,
// entry_row0..3 and last_column; four transfers per matrix, columns 0 to 3,
// last_column high on column 3.
// After the first column, the rest follow one per cycle while the receiver
// takes them. A matrix leaves as four column transfers on the single output
// port; the CORDIC and multiplier pipeline takes an item every cycle while
// o_stall is low.
// Reset clears all valid bits; the pipeline comes up empty and ready.
// When the receiver stalls, the held column stays put, the whole pipeline
// freezes once its last stage holds an item, and o_stall rises.
// ----------------------------------------------------------------------------
module trs_matrix_builder
    import trs_pkg::*;
#(
    parameter int unsigned CORDIC_STAGES = CordicStagesDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_position_x,
    input  logic signed [31:0] i_position_y,
    input  logic signed [31:0] i_position_z,
    input  logic signed [31:0] i_scale_x,
    input  logic signed [31:0] i_scale_y,
    input  logic signed [31:0] i_scale_z,
    input  logic signed [15:0] i_angle_x,
    input  logic signed [15:0] i_angle_y,
    input  logic signed [15:0] i_angle_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_column_index,
    output logic signed [31:0] o_entry_row0,
    output logic signed [31:0] o_entry_row1,
    output logic signed [31:0] o_entry_row2,
    output logic signed [31:0] o_entry_row3,
    output logic               o_last_column
);

    localparam int unsigned Ld = CORDIC_STAGES + 3;

    logic w_adv;
    logic w_load;

    t_q32 w_sx, w_cx, w_sy, w_cy, w_sz, w_cz;

    logic r_dv   [Ld];
    t_q32 r_dpos [Ld][3];
    t_q32 r_dscl [Ld][3];

    logic r_m1_v;
    t_q32 r_m1_pos [3];
    t_q32 r_m1_scl [3];
    t_q32 r_m1_p00, r_m1_p02, r_m1_p10, r_m1_p12;
    t_q32 r_m1_sz, r_m1_cz, r_m1_sy, r_m1_cy, r_m1_sx, r_m1_cx;

    logic r_m2_v;
    t_q32 r_m2_pos [3];
    t_q32 r_m2_scl [3];
    t_q32 r_m2_r0  [3];
    t_q32 r_m2_a   [2];
    t_q32 r_m2_b   [2];
    t_q32 r_m2_c   [2];
    t_q32 r_m2_d   [2];
    t_q32 r_m2_r21, r_m2_r22;

    logic r_m3_v;
    t_q32 r_m3_pos [3];
    t_q32 r_m3_scl [3];
    t_q32 r_m3_r   [3][3];

    logic              r_m4_v;
    t_q32              r_m4_pos [3];
    logic signed [63:0] r_m4_p  [3][3];

    logic r_m5_v;
    t_q32 r_m5_pos [3];
    t_q32 r_m5_m   [3][3];

    logic       r_out_valid;
    logic [1:0] r_col;
    t_q32       r_hpos [3];
    t_q32       r_hm   [3][3];

    assign w_load  = !r_out_valid || (!i_stall && r_col == LastCol);
    assign w_adv   = !r_m5_v || w_load;
    assign o_stall = !w_adv;

    trs_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_x (
        .i_clk(i_clk), .i_en(w_adv), .i_angle(i_angle_x), .o_sin(w_sx), .o_cos(w_cx)
    );
    trs_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_y (
        .i_clk(i_clk), .i_en(w_adv), .i_angle(i_angle_y), .o_sin(w_sy), .o_cos(w_cy)
    );
    trs_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_z (
        .i_clk(i_clk), .i_en(w_adv), .i_angle(i_angle_z), .o_sin(w_sz), .o_cos(w_cz)
    );

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < Ld; k++) begin
                r_dv[k] <= 1'b0;
            end
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
            r_m3_v <= 1'b0;
            r_m4_v <= 1'b0;
            r_m5_v <= 1'b0;
        end else if (w_adv) begin
            r_dv[0] <= i_valid;
            for (int k = 1; k < Ld; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
            r_m1_v <= r_dv[Ld-1];
            r_m2_v <= r_m1_v;
            r_m3_v <= r_m2_v;
            r_m4_v <= r_m3_v;
            r_m5_v <= r_m4_v;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dpos[0][0] <= i_position_x;
            r_dpos[0][1] <= i_position_y;
            r_dpos[0][2] <= i_position_z;
            r_dscl[0][0] <= i_scale_x;
            r_dscl[0][1] <= i_scale_y;
            r_dscl[0][2] <= i_scale_z;
            for (int k = 1; k < Ld; k++) begin
                r_dpos[k] <= r_dpos[k-1];
                r_dscl[k] <= r_dscl[k-1];
            end

            // Rz*Ry products
            r_m1_pos <= r_dpos[Ld-1];
            r_m1_scl <= r_dscl[Ld-1];
            r_m1_p00 <= mul30(w_cz, w_cy);
            r_m1_p02 <= mul30(w_cz, -w_sy);
            r_m1_p10 <= mul30(-w_sz, w_cy);
            r_m1_p12 <= mul30(-w_sz, -w_sy);
            r_m1_sz  <= w_sz;
            r_m1_cz  <= w_cz;
            r_m1_sy  <= w_sy;
            r_m1_cy  <= w_cy;
            r_m1_sx  <= w_sx;
            r_m1_cx  <= w_cx;

            // (Rz*Ry)*Rx products
            r_m2_pos   <= r_m1_pos;
            r_m2_scl   <= r_m1_scl;
            r_m2_r0[0] <= r_m1_p00;
            r_m2_r0[1] <= r_m1_p10;
            r_m2_r0[2] <= r_m1_sy;
            r_m2_a[0]  <= mul30(r_m1_sz, r_m1_cx);
            r_m2_b[0]  <= mul30(r_m1_p02, -r_m1_sx);
            r_m2_c[0]  <= mul30(r_m1_sz, r_m1_sx);
            r_m2_d[0]  <= mul30(r_m1_p02, r_m1_cx);
            r_m2_a[1]  <= mul30(r_m1_cz, r_m1_cx);
            r_m2_b[1]  <= mul30(r_m1_p12, -r_m1_sx);
            r_m2_c[1]  <= mul30(r_m1_cz, r_m1_sx);
            r_m2_d[1]  <= mul30(r_m1_p12, r_m1_cx);
            r_m2_r21   <= mul30(r_m1_cy, -r_m1_sx);
            r_m2_r22   <= mul30(r_m1_cy, r_m1_cx);

            // sums
            r_m3_pos <= r_m2_pos;
            r_m3_scl <= r_m2_scl;
            for (int i = 0; i < 2; i++) begin
                r_m3_r[i][0] <= r_m2_r0[i];
                r_m3_r[i][1] <= r_m2_a[i] + r_m2_b[i];
                r_m3_r[i][2] <= r_m2_c[i] + r_m2_d[i];
            end
            r_m3_r[2][0] <= r_m2_r0[2];
            r_m3_r[2][1] <= r_m2_r21;
            r_m3_r[2][2] <= r_m2_r22;

            // scale
            r_m4_pos <= r_m3_pos;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_m4_p[i][j] <= r_m3_r[i][j] * r_m3_scl[j];
                end
            end

            // round and saturate
            r_m5_pos <= r_m4_pos;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_m5_m[i][j] <= rnd_sat(r_m4_p[i][j]);
                end
            end
        end
    end

    // column serialiser
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_col       <= '0;
        end else if (w_load) begin
            r_out_valid <= r_m5_v;
            r_col       <= '0;
        end else if (!i_stall) begin
            r_col <= r_col + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && r_m5_v) begin
            r_hpos <= r_m5_pos;
            r_hm   <= r_m5_m;
        end
    end

    always_comb begin
        case (r_col)
            2'd0: begin
                o_entry_row0 = r_hm[0][0];
                o_entry_row1 = r_hm[1][0];
                o_entry_row2 = r_hm[2][0];
                o_entry_row3 = '0;
            end
            2'd1: begin
                o_entry_row0 = r_hm[0][1];
                o_entry_row1 = r_hm[1][1];
                o_entry_row2 = r_hm[2][1];
                o_entry_row3 = '0;
            end
            2'd2: begin
                o_entry_row0 = r_hm[0][2];
                o_entry_row1 = r_hm[1][2];
                o_entry_row2 = r_hm[2][2];
                o_entry_row3 = '0;
            end
            default: begin
                o_entry_row0 = r_hpos[0];
                o_entry_row1 = r_hpos[1];
                o_entry_row2 = r_hpos[2];
                o_entry_row3 = UnityQ;
            end
        endcase
    end

    assign o_valid        = r_out_valid;
    assign o_column_index = r_col;
    assign o_last_column  = (r_col == LastCol);

`include "assert_macros.svh"

    `ASSERT_NEXT(a_col_step, r_out_valid && !i_stall && r_col != LastCol, r_out_valid && r_col == $past(r_col) + 2'd1, "column did not advance")
    `ASSERT_NEXT(a_col_hold, r_out_valid && i_stall, r_out_valid && $stable(r_col), "held column changed")
    `ASSERT_NOW(a_stall_src, o_stall, r_m5_v && r_out_valid, "stall without a waiting item")

endmodule

FILE: hw/rtl/trs_cordic.sv
// ----------------------------------------------------------------------------
// trs_cordic
// Pipelined sine/cosine lane: range wrap, quadrant fold, one CORDIC
// iteration per stage, sign fix-up.
// ----------------------------------------------------------------------------
module trs_cordic
    import trs_pkg::*;
#(
    parameter int unsigned CORDIC_STAGES = CordicStagesDef
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [15:0]  i_angle,
    output t_q32                o_sin,
    output t_q32                o_cos
);

    t_ang  r_wa;
    t_ang  n_wa;
    t_ang  r_fa;
    t_ang  n_fa;
    logic  r_fneg;
    logic  n_fneg;

    t_cvec r_x  [CORDIC_STAGES];
    t_cvec r_y  [CORDIC_STAGES];
    t_ang  r_a  [CORDIC_STAGES];
    logic  r_ng [CORDIC_STAGES];

    t_q32  r_sin;
    t_q32  r_cos;

    always_comb begin
        t_ang a0;
        a0 = {i_angle[15], i_angle, 18'd0};
        if (a0 > PiQ30) begin
            n_wa = a0 - TwoPiQ30;
        end else if (a0 < -PiQ30) begin
            n_wa = a0 + TwoPiQ30;
        end else begin
            n_wa = a0;
        end
    end

    always_comb begin
        if (r_wa > HalfPiQ30) begin
            n_fa   = r_wa - PiQ30;
            n_fneg = 1'b1;
        end else if (r_wa < -HalfPiQ30) begin
            n_fa   = r_wa + PiQ30;
            n_fneg = 1'b1;
        end else begin
            n_fa   = r_wa;
            n_fneg = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wa   <= n_wa;
            r_fa   <= n_fa;
            r_fneg <= n_fneg;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        t_cvec px;
        t_cvec py;
        t_ang  pa;
        logic  pn;
        t_ang  at;

        if (i == 0) begin : g_first
            assign px = GainQ30;
            assign py = '0;
            assign pa = r_fa;
            assign pn = r_fneg;
        end else begin : g_next
            assign px = r_x[i-1];
            assign py = r_y[i-1];
            assign pa = r_a[i-1];
            assign pn = r_ng[i-1];
        end

        assign at = $signed({3'd0, AtanQ30[i]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (pa >= 0) begin
                    r_x[i] <= px - (py >>> i);
                    r_y[i] <= py + (px >>> i);
                    r_a[i] <= pa - at;
                end else begin
                    r_x[i] <= px + (py >>> i);
                    r_y[i] <= py - (px >>> i);
                    r_a[i] <= pa + at;
                end
                r_ng[i] <= pn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_ng[CORDIC_STAGES-1]) begin
                r_sin <= t_q32'(-r_y[CORDIC_STAGES-1]);
                r_cos <= t_q32'(-r_x[CORDIC_STAGES-1]);
            end else begin
                r_sin <= t_q32'(r_y[CORDIC_STAGES-1]);
                r_cos <= t_q32'(r_x[CORDIC_STAGES-1]);
            end
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule
